@@ rtl/csfr_pkg.sv @@
package csfr_pkg;

   localparam int ID_W       = 29;
   localparam int PAYLOAD_W  = 56;
   localparam int NUM_W      = 6;
   localparam int DLEN_W     = 4;
   localparam int LEN_W      = 7;
   localparam int AGE_W      = 16;
   localparam int NB_W       = 3;
   localparam int BYTES_PER_CHUNK = 7;
   localparam int MAX_BYTES  = 112;   // 16 chunks out per message at most

   localparam logic [AGE_W-1:0] TIMEOUT_RESET = 16'd5000;

   typedef enum logic [1:0] {
      SEG_SINGLE = 2'd0,
      SEG_BEGIN  = 2'd1,
      SEG_MIDDLE = 2'd2,
      SEG_END    = 2'd3
   } seg_type_type;

   typedef enum logic {
      MODE_FRAME = 1'b0,
      MODE_TICK  = 1'b1
   } mode_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;
      logic tick;
      logic expire;
      logic lookup;
      logic apply;
      logic merge;
      logic emit_read;
      logic emit_load;
      logic release_slot;
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      mode_type     item_mode;
      seg_type_type item_seg;
      logic         hit;
      logic         need_merge;
      logic         emit_last;
      logic         out_free;
   } dp_status_type;

   function automatic logic [PAYLOAD_W-1:0] low_bytes_mask(input logic [NB_W-1:0] n);
      logic [PAYLOAD_W-1:0] m;
      m = '0;
      for (int b = 0; b < BYTES_PER_CHUNK; b++) begin
         if (NB_W'(b) < n) begin
            m[b*8 +: 8] = 8'hFF;
         end
      end
      return m;
   endfunction

endpackage

@@ rtl/csfr_ram.sv @@
module csfr_ram #(
   parameter int WIDTH = 56,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/csfr_ctrl.sv @@
module csfr_ctrl
   import csfr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type sts,
   output ctrl_cmd_type  cmd
);

   typedef enum logic [7:0] {
      S_IDLE    = 8'b0000_0001,
      S_DECODE  = 8'b0000_0010,
      S_EXPIRE  = 8'b0000_0100,
      S_LOOKUP  = 8'b0000_1000,
      S_APPLY   = 8'b0001_0000,
      S_MERGE   = 8'b0010_0000,
      S_EMIT_RD = 8'b0100_0000,
      S_EMIT_LD = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (sts.item_mode == MODE_TICK) begin
               cmd.tick = 1'b1;
               state_in = S_IDLE;
            end else if (sts.item_seg == SEG_SINGLE) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_EXPIRE;
            end
         end
         S_EXPIRE: begin
            cmd.expire = 1'b1;
            state_in   = S_LOOKUP;
         end
         S_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = S_APPLY;
         end
         S_APPLY: begin
            cmd.apply = 1'b1;
            if (!sts.hit || sts.item_seg != SEG_END) begin
               state_in = S_IDLE;
            end else if (sts.need_merge) begin
               state_in = S_MERGE;
            end else begin
               state_in = S_EMIT_RD;
            end
         end
         S_MERGE: begin
            cmd.merge = 1'b1;
            state_in  = S_EMIT_RD;
         end
         S_EMIT_RD: begin
            cmd.emit_read = 1'b1;
            state_in      = S_EMIT_LD;
         end
         S_EMIT_LD: begin
            if (sts.out_free) begin
               cmd.emit_load = 1'b1;
               if (sts.emit_last) begin
                  cmd.release_slot = 1'b1;
                  state_in         = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

endmodule

@@ rtl/csfr_datapath.sv @@
module csfr_datapath
   import csfr_pkg::*;
#(
   parameter int SLOTS           = 4,
   parameter int CHUNKS_PER_SLOT = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ctrl_cmd_type         cmd,
   output dp_status_type        sts,
   input  logic                 req_mode,
   input  logic [ID_W-1:0]      req_frame_id,
   input  logic [1:0]           req_seg_type,
   input  logic [NUM_W-1:0]     req_seg_num,
   input  logic [PAYLOAD_W-1:0] req_payload,
   input  logic [DLEN_W-1:0]    req_data_len,
   input  logic                 csr_valid,
   input  logic [AGE_W-1:0]     csr_timeout_ticks,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [ID_W-1:0]      rsp_msg_id,
   output logic [PAYLOAD_W-1:0] rsp_chunk,
   output logic [2:0]           rsp_chunk_bytes,
   output logic [LEN_W-1:0]     rsp_total_len,
   output logic                 rsp_last
);

   localparam int DEPTH = SLOTS * CHUNKS_PER_SLOT;
   localparam int AW    = $clog2(DEPTH);
   localparam int SEL_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int KW    = $clog2(CHUNKS_PER_SLOT + 1);
   localparam int CAP   = (CHUNKS_PER_SLOT * BYTES_PER_CHUNK < MAX_BYTES) ?
                          CHUNKS_PER_SLOT * BYTES_PER_CHUNK : MAX_BYTES;

   function automatic logic [AW-1:0] slot_addr(input logic [SEL_W-1:0] s,
                                               input logic [LEN_W-1:0] idx);
      return AW'(int'(s) * CHUNKS_PER_SLOT + int'(idx));
   endfunction

   function automatic logic [LEN_W-1:0] grow(input logic [LEN_W-1:0] len,
                                             input logic [NB_W:0]    n);
      logic [LEN_W:0] sum;
      sum = {1'b0, len} + (LEN_W+1)'(n);
      return (sum > (LEN_W+1)'(CAP)) ? LEN_W'(CAP) : sum[LEN_W-1:0];
   endfunction

   // latched request
   mode_type             item_mode_ff;
   seg_type_type         item_seg_ff;
   logic [ID_W-1:0]      item_id_ff;
   logic [NUM_W-1:0]     item_num_ff;
   logic [PAYLOAD_W-1:0] item_data_ff;
   logic [NB_W-1:0]      item_nb_ff;
   logic [NB_W-1:0]      nb_in;

   logic [AGE_W-1:0]     timeout_ff;

   // slot table
   logic [ID_W-1:0]  slot_ident_ff [SLOTS];
   logic [ID_W-1:0]  slot_ident_in [SLOTS];
   logic [LEN_W-1:0] slot_len_ff   [SLOTS];
   logic [LEN_W-1:0] slot_len_in   [SLOTS];
   logic [AGE_W-1:0] slot_age_ff   [SLOTS];
   logic [AGE_W-1:0] slot_age_in   [SLOTS];

   logic [SEL_W-1:0] sel_ff, sel_in;
   logic             hit_ff, hit_in;
   logic [SLOTS-1:0] match_vec, free_vec;
   logic [SEL_W-1:0] match_sel, free_sel;

   // emission
   logic [KW-1:0]    k_ff, k_in;
   logic [LEN_W-1:0] rem_ff, rem_in;
   logic             num_ok;
   logic             emit_last;
   logic [2:0]       cb;

   // chunk store
   logic                 ram_wr_en, ram_rd_en;
   logic [AW-1:0]        ram_wr_addr, ram_rd_addr;
   logic [PAYLOAD_W-1:0] ram_wr_data, ram_rd_data;
   logic [DEPTH-1:0]     valid_ff, valid_in;
   logic                 rvalid_ff;
   logic [PAYLOAD_W-1:0] old_word, merged, nb_mask;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]      rsp_msg_id_ff;
   logic [PAYLOAD_W-1:0] rsp_chunk_ff;
   logic [2:0]           rsp_chunk_bytes_ff;
   logic [LEN_W-1:0]     rsp_total_len_ff;
   logic                 rsp_last_ff;
   logic                 out_free;

   // DLC includes the header byte; clamp to one chunk
   always_comb begin
      if (req_data_len == '0) begin
         nb_in = '0;
      end else if (req_data_len > DLEN_W'(8)) begin
         nb_in = NB_W'(BYTES_PER_CHUNK);
      end else begin
         nb_in = NB_W'(req_data_len - DLEN_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_mode_ff <= mode_type'(req_mode);
         item_seg_ff  <= seg_type_type'(req_seg_type);
         item_id_ff   <= req_frame_id;
         item_num_ff  <= req_seg_num;
         item_data_ff <= req_payload;
         item_nb_ff   <= nb_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_valid) begin
         timeout_ff <= csr_timeout_ticks;
      end
   end

   assign num_ok = (int'(item_num_ff) < CHUNKS_PER_SLOT);

   // slot search, lowest index wins
   always_comb begin
      match_sel = '0;
      free_sel  = '0;
      for (int i = 0; i < SLOTS; i++) begin
         match_vec[i] = (slot_len_ff[i] != '0) && (slot_ident_ff[i] == item_id_ff);
         free_vec[i]  = (slot_len_ff[i] == '0);
      end
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (match_vec[i]) match_sel = SEL_W'(i);
         if (free_vec[i])  free_sel  = SEL_W'(i);
      end
   end

   always_comb begin
      sel_in = sel_ff;
      hit_in = hit_ff;
      if (cmd.lookup) begin
         if (|match_vec) begin
            sel_in = match_sel;
            hit_in = 1'b1;
         end else if (item_seg_ff == SEG_BEGIN && (|free_vec)) begin
            sel_in = free_sel;
            hit_in = 1'b1;
         end else begin
            hit_in = 1'b0;
         end
      end
   end

   // slot table update
   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         slot_ident_in[i] = slot_ident_ff[i];
         slot_len_in[i]   = slot_len_ff[i];
         slot_age_in[i]   = slot_age_ff[i];
         if (cmd.tick && slot_len_ff[i] != '0 && slot_age_ff[i] != '1) begin
            slot_age_in[i] = slot_age_ff[i] + AGE_W'(1);
         end
         if (cmd.expire && slot_len_ff[i] != '0 && slot_age_ff[i] > timeout_ff) begin
            slot_len_in[i]   = '0;
            slot_ident_in[i] = '0;
         end
      end
      if (cmd.apply && hit_ff) begin
         case (item_seg_ff)
            SEG_BEGIN: begin
               slot_len_in[sel_ff]   = LEN_W'(BYTES_PER_CHUNK);
               slot_ident_in[sel_ff] = item_id_ff;
               slot_age_in[sel_ff]   = '0;
            end
            SEG_MIDDLE: begin
               slot_len_in[sel_ff] = grow(slot_len_ff[sel_ff], (NB_W+1)'(BYTES_PER_CHUNK));
               slot_age_in[sel_ff] = '0;
            end
            SEG_END: begin
               slot_len_in[sel_ff] = grow(slot_len_ff[sel_ff], {1'b0, item_nb_ff});
               slot_age_in[sel_ff] = '0;
            end
            default: begin
            end
         endcase
      end
      if (cmd.release_slot) begin
         slot_len_in[sel_ff]   = '0;
         slot_ident_in[sel_ff] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            slot_ident_ff[i] <= '0;
            slot_len_ff[i]   <= '0;
            slot_age_ff[i]   <= '0;
         end
         sel_ff <= '0;
         hit_ff <= 1'b0;
      end else begin
         for (int i = 0; i < SLOTS; i++) begin
            slot_ident_ff[i] <= slot_ident_in[i];
            slot_len_ff[i]   <= slot_len_in[i];
            slot_age_ff[i]   <= slot_age_in[i];
         end
         sel_ff <= sel_in;
         hit_ff <= hit_in;
      end
   end

   // chunk store access
   assign old_word = rvalid_ff ? ram_rd_data : '0;
   assign nb_mask  = low_bytes_mask(item_nb_ff);
   assign merged   = (old_word & ~nb_mask) | (item_data_ff & nb_mask);

   assign emit_last = (rem_ff <= LEN_W'(BYTES_PER_CHUNK));
   assign cb        = emit_last ? rem_ff[2:0] : 3'(BYTES_PER_CHUNK);

   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = slot_addr(sel_ff, LEN_W'(item_num_ff));
      ram_wr_data = item_data_ff;
      ram_rd_en   = 1'b0;
      ram_rd_addr = slot_addr(sel_ff, LEN_W'(k_ff));
      k_in        = k_ff;
      rem_in      = rem_ff;
      if (cmd.apply && hit_ff) begin
         case (item_seg_ff)
            SEG_BEGIN: begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = slot_addr(sel_ff, '0);
            end
            SEG_MIDDLE: begin
               ram_wr_en = num_ok;
            end
            SEG_END: begin
               // partial write: fetch the old word first
               ram_rd_en   = num_ok;
               ram_rd_addr = slot_addr(sel_ff, LEN_W'(item_num_ff));
               k_in        = '0;
               rem_in      = slot_len_in[sel_ff];
            end
            default: begin
            end
         endcase
      end
      if (cmd.merge) begin
         ram_wr_en   = 1'b1;
         ram_wr_data = merged;
      end
      if (cmd.emit_read || (cmd.emit_load && !emit_last)) begin
         ram_rd_en = 1'b1;
         k_in      = k_ff + KW'(1);
      end
      if (cmd.emit_load) begin
         rem_in = rem_ff - LEN_W'(BYTES_PER_CHUNK);
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (ram_wr_en) begin
         valid_in[ram_wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff   <= k_in;
      rem_ff <= rem_in;
      if (ram_rd_en) begin
         rvalid_ff <= valid_ff[ram_rd_addr];
      end
   end

   csfr_ram #(
      .WIDTH (PAYLOAD_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // result register
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_load) begin
         rsp_msg_id_ff      <= slot_ident_ff[sel_ff];
         rsp_chunk_ff       <= old_word & low_bytes_mask(cb);
         rsp_chunk_bytes_ff <= cb;
         rsp_total_len_ff   <= slot_len_ff[sel_ff];
         rsp_last_ff        <= emit_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_msg_id      = rsp_msg_id_ff;
   assign rsp_chunk       = rsp_chunk_ff;
   assign rsp_chunk_bytes = rsp_chunk_bytes_ff;
   assign rsp_total_len   = rsp_total_len_ff;
   assign rsp_last        = rsp_last_ff;

   assign sts.item_mode  = item_mode_ff;
   assign sts.item_seg   = item_seg_ff;
   assign sts.hit        = hit_ff;
   assign sts.need_merge = (item_seg_ff == SEG_END) && num_ok;
   assign sts.emit_last  = emit_last;
   assign sts.out_free   = out_free;

`ifndef NO_ASSERTIONS
   a_load_into_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten before it was taken");

   a_len_capped: assert property (@(posedge clock) disable iff (reset)
      slot_len_ff[sel_ff] <= LEN_W'(CAP))
      else $error("slot length above capacity");

   a_release_frees: assert property (@(posedge clock) disable iff (reset)
      cmd.release_slot |=> slot_len_ff[$past(sel_ff)] == '0)
      else $error("slot still in use after release");

   a_wr_in_range: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> ({1'b0, ram_wr_addr} < (AW+1)'(DEPTH)))
      else $error("chunk store write out of range");
`endif

endmodule

@@ rtl/can_segmented_frame_reassembler_core.sv @@
// Segmented CAN message reassembler.
// Steps: a tick is captured and decoded; a single segment is captured, decoded and dropped.
// Other segments are captured and decoded, idle slots expired, the slot looked up and
// the segment applied; an end segment that found its slot then merges its partial chunk
// when in range, reads the store and streams one chunk per cycle while rsp_ready is high.
// One request at a time, paced by one chunk store read per chunk; the last may still wait.
// Reset: synchronous; slots freed, timeout 5000, chunk store marked all zero at once.
module can_segmented_frame_reassembler_core
   import csfr_pkg::*;
#(
   parameter int SLOTS           = 4,
   parameter int CHUNKS_PER_SLOT = 16
) (
   input  logic                 clock,
   input  logic                 reset,

   // request channel: one received frame or one time tick
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_mode,
   input  logic [ID_W-1:0]      req_frame_id,
   input  logic [1:0]           req_seg_type,
   input  logic [NUM_W-1:0]     req_seg_num,
   input  logic [PAYLOAD_W-1:0] req_payload,
   input  logic [DLEN_W-1:0]    req_data_len,

   // result channel: one chunk, up to 7 bytes, of a finished message
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [ID_W-1:0]      rsp_msg_id,
   output logic [PAYLOAD_W-1:0] rsp_chunk,
   output logic [2:0]           rsp_chunk_bytes,
   output logic [LEN_W-1:0]     rsp_total_len,
   output logic                 rsp_last,

   // timeout register write
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [AGE_W-1:0]     csr_timeout_ticks
);

   ctrl_cmd_type  cmd;
   dp_status_type sts;

   // The register is a plain flop; a write is always taken.
   assign csr_ready = 1'b1;

   // Sequencer: decode, expire idle slots, look up the slot, apply the segment,
   // then for an end segment merge the partial chunk and stream the message out.
   csfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Slot table, chunk store and result register.
   csfr_datapath #(
      .SLOTS           (SLOTS),
      .CHUNKS_PER_SLOT (CHUNKS_PER_SLOT)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_mode          (req_mode),
      .req_frame_id      (req_frame_id),
      .req_seg_type      (req_seg_type),
      .req_seg_num       (req_seg_num),
      .req_payload       (req_payload),
      .req_data_len      (req_data_len),
      .csr_valid         (csr_valid),
      .csr_timeout_ticks (csr_timeout_ticks),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_msg_id        (rsp_msg_id),
      .rsp_chunk         (rsp_chunk),
      .rsp_chunk_bytes   (rsp_chunk_bytes),
      .rsp_total_len     (rsp_total_len),
      .rsp_last          (rsp_last)
   );

endmodule

@@ tb/sv/csfr_tb_pkg.sv @@
`timescale 1ns / 1ps

package csfr_tb_pkg;
   import csfr_pkg::*;

   localparam int TB_SLOTS  = 4;
   localparam int TB_CHUNKS = 16;
   localparam int AGE_MAX   = 65535;
   localparam int CAP_BYTES = (TB_CHUNKS * BYTES_PER_CHUNK < MAX_BYTES) ?
                              TB_CHUNKS * BYTES_PER_CHUNK : MAX_BYTES;

   typedef struct packed {
      logic [ID_W-1:0]      msg_id;
      logic [PAYLOAD_W-1:0] chunk;
      logic [2:0]           chunk_bytes;
      logic [LEN_W-1:0]     total_len;
      logic                 last;
   } chunk_rec_type;

   class reassembly_scoreboard;
      logic [ID_W-1:0]      slot_ident [TB_SLOTS];
      int                   slot_len   [TB_SLOTS];
      int                   slot_age   [TB_SLOTS];
      logic [PAYLOAD_W-1:0] chunk_mem  [TB_SLOTS*TB_CHUNKS];
      int                   timeout_ticks;
      chunk_rec_type        due_chunks [$];
      int failures;
      int chunks_checked;
      int messages_done;
      int ticks_seen;
      int frames_seen;
      int expiries;

      function new();
         foreach (slot_ident[i]) begin
            slot_ident[i] = '0;
            slot_len[i]   = 0;
            slot_age[i]   = 0;
         end
         foreach (chunk_mem[i]) chunk_mem[i] = '0;
         timeout_ticks  = int'(TIMEOUT_RESET);
         failures       = 0;
         chunks_checked = 0;
         messages_done  = 0;
         ticks_seen     = 0;
         frames_seen    = 0;
         expiries       = 0;
      endfunction

      function void set_timeout(logic [AGE_W-1:0] t);
         timeout_ticks = int'(t);
      endfunction

      function int outstanding();
         return due_chunks.size();
      endfunction

      // low n bytes set, n clipped to one chunk
      function logic [PAYLOAD_W-1:0] byte_mask(int n);
         if (n >= BYTES_PER_CHUNK) return '1;
         return (PAYLOAD_W'(1) << (8 * n)) - PAYLOAD_W'(1);
      endfunction

      function void grow(int s, int n);
         slot_len[s] = (slot_len[s] + n > CAP_BYTES) ? CAP_BYTES : slot_len[s] + n;
      endfunction

      // keep stored bytes above n, drop writes past the slot
      function void store_bytes(int s, int pos, logic [PAYLOAD_W-1:0] data, int n);
         logic [PAYLOAD_W-1:0] m;
         if (pos >= TB_CHUNKS) return;
         m = byte_mask(n);
         chunk_mem[s*TB_CHUNKS+pos] = (chunk_mem[s*TB_CHUNKS+pos] & ~m) | (data & m);
      endfunction

      function void note_request(mode_type mode, logic [ID_W-1:0] ident,
                                 seg_type_type seg, logic [NUM_W-1:0] num,
                                 logic [PAYLOAD_W-1:0] data, logic [DLEN_W-1:0] dlen);
         int hit;
         int nb;
         int nch;
         int rest;
         chunk_rec_type rec;
         if (mode == MODE_TICK) begin
            ticks_seen++;
            foreach (slot_len[i])
               if (slot_len[i] != 0 && slot_age[i] < AGE_MAX) slot_age[i]++;
            return;
         end
         frames_seen++;
         if (seg == SEG_SINGLE) return;
         foreach (slot_len[i]) begin
            if (slot_len[i] != 0 && slot_age[i] > timeout_ticks) begin
               slot_ident[i] = '0;
               slot_len[i]   = 0;
               expiries++;
            end
         end
         hit = -1;
         foreach (slot_len[i])
            if (hit < 0 && slot_len[i] != 0 && slot_ident[i] == ident) hit = i;
         if (seg == SEG_BEGIN) begin
            foreach (slot_len[i])
               if (hit < 0 && slot_len[i] == 0) hit = i;
            if (hit < 0) return;
            chunk_mem[hit*TB_CHUNKS] = data;
            slot_len[hit] = 0;
            grow(hit, BYTES_PER_CHUNK);
            slot_ident[hit] = ident;
            slot_age[hit]   = 0;
            return;
         end
         if (hit < 0) return;
         slot_age[hit] = 0;
         if (seg == SEG_MIDDLE) begin
            store_bytes(hit, int'(num), data, BYTES_PER_CHUNK);
            grow(hit, BYTES_PER_CHUNK);
            return;
         end
         nb = (dlen == '0) ? 0 : int'(dlen) - 1;
         if (nb > BYTES_PER_CHUNK) nb = BYTES_PER_CHUNK;
         store_bytes(hit, int'(num), data, nb);
         grow(hit, nb);
         nch = (slot_len[hit] + BYTES_PER_CHUNK - 1) / BYTES_PER_CHUNK;
         for (int k = 0; k < nch; k++) begin
            rest = slot_len[hit] - BYTES_PER_CHUNK * k;
            if (rest > BYTES_PER_CHUNK) rest = BYTES_PER_CHUNK;
            rec.msg_id      = slot_ident[hit];
            rec.chunk       = chunk_mem[hit*TB_CHUNKS+k] & byte_mask(rest);
            rec.chunk_bytes = 3'(rest);
            rec.total_len   = LEN_W'(slot_len[hit]);
            rec.last        = (k == nch - 1);
            due_chunks.push_back(rec);
         end
         messages_done++;
         slot_ident[hit] = '0;
         slot_len[hit]   = 0;
      endfunction

      function void check_chunk(chunk_rec_type got);
         chunk_rec_type want;
         if (due_chunks.size() == 0) begin
            if (failures < 10)
               $display("%0t: unexpected chunk id=%h chunk=%h bytes=%0d len=%0d last=%0d",
                        $time, got.msg_id, got.chunk, got.chunk_bytes, got.total_len,
                        got.last);
            failures++;
            return;
         end
         want = due_chunks.pop_front();
         chunks_checked++;
         if (got.msg_id !== want.msg_id || got.chunk !== want.chunk ||
             got.chunk_bytes !== want.chunk_bytes || got.total_len !== want.total_len ||
             got.last !== want.last) begin
            if (failures < 10) begin
               $display("%0t: chunk mismatch", $time);
               $display("   expected id=%h chunk=%h bytes=%0d len=%0d last=%0d",
                        want.msg_id, want.chunk, want.chunk_bytes, want.total_len, want.last);
               $display("   actual   id=%h chunk=%h bytes=%0d len=%0d last=%0d",
                        got.msg_id, got.chunk, got.chunk_bytes, got.total_len, got.last);
            end
            failures++;
         end
      endfunction
   endclass

endpackage

@@ tb/sv/can_segmented_frame_reassembler_core_tb.sv @@
`timescale 1ns / 1ps

module can_segmented_frame_reassembler_core_tb;
   import csfr_pkg::*;
   import csfr_tb_pkg::*;

   // cycles with no handshake on any port before the run is declared hung;
   // covers the long output hold, the longest stalls and the settle pauses
   localparam int IDLE_LIMIT      = 4000;
   // quiet time after the last chunk, long enough for a request that produced no chunk to finish
   localparam int SETTLE_CYCLES   = 30;
   localparam int RSP_HOLD_CYCLES = 400;
   localparam int TICK_BURST      = 12;
   localparam logic [ID_W-1:0] ID_TOP = '1;

   logic                 clock;
   logic                 reset             = 1'b1;
   logic                 req_valid         = 1'b0;
   logic                 req_ready;
   logic                 req_mode          = 1'b0;
   logic [ID_W-1:0]      req_frame_id      = '0;
   logic [1:0]           req_seg_type      = '0;
   logic [NUM_W-1:0]     req_seg_num       = '0;
   logic [PAYLOAD_W-1:0] req_payload       = '0;
   logic [DLEN_W-1:0]    req_data_len      = '0;
   logic                 rsp_valid;
   logic                 rsp_ready         = 1'b0;
   logic [ID_W-1:0]      rsp_msg_id;
   logic [PAYLOAD_W-1:0] rsp_chunk;
   logic [2:0]           rsp_chunk_bytes;
   logic [LEN_W-1:0]     rsp_total_len;
   logic                 rsp_last;
   logic                 csr_valid         = 1'b0;
   logic                 csr_ready;
   logic [AGE_W-1:0]     csr_timeout_ticks = '0;

   reassembly_scoreboard sb;

   bit rsp_hold_req;    // asks the response side for one long hold-off
   bit sender_gaps;     // off during the tick burst
   int zero_gap_left;   // stretch of back-to-back requests
   int timeout_mid;
   int timeout_last;

   can_segmented_frame_reassembler_core u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_frame_id      (req_frame_id),
      .req_seg_type      (req_seg_type),
      .req_seg_num       (req_seg_num),
      .req_payload       (req_payload),
      .req_data_len      (req_data_len),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_msg_id        (rsp_msg_id),
      .rsp_chunk         (rsp_chunk),
      .rsp_chunk_bytes   (rsp_chunk_bytes),
      .rsp_total_len     (rsp_total_len),
      .rsp_last          (rsp_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_timeout_ticks (csr_timeout_ticks)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Random value helpers
   // ---------------------------------------------------------------------
   function automatic logic [PAYLOAD_W-1:0] rand_payload();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8) return '1;
      if (r < 12) return '0;
      return PAYLOAD_W'({$urandom, $urandom});
   endfunction

   // small id set on top of random ones, so messages collide on slots
   function automatic logic [ID_W-1:0] rand_ident();
      int r;
      r = $urandom_range(0, 99);
      if (r < 12) return '0;
      if (r < 24) return ID_TOP;
      if (r < 50) return ID_W'(29'h0A5A_5A50 + $urandom_range(0, 3));
      return ID_W'($urandom);
   endfunction

   // mostly legal lengths, sometimes zero or above eight
   function automatic logic [DLEN_W-1:0] pick_dlen();
      if ($urandom_range(0, 9) == 0) return DLEN_W'($urandom_range(0, 15));
      return DLEN_W'($urandom_range(1, 8));
   endfunction

   function automatic int pick_gap();
      int r;
      if (!sender_gaps) return 0;
      if (zero_gap_left > 0) begin
         zero_gap_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         zero_gap_left = $urandom_range(20, 80);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(5, 20);
      return $urandom_range(30, 60);
   endfunction

   // ---------------------------------------------------------------------
   // Request side. Called only at a rising edge; valid stays up across
   // back-to-back requests and is dropped only for a gap.
   // ---------------------------------------------------------------------
   task automatic drive_request(mode_type mode, logic [ID_W-1:0] ident, seg_type_type seg,
                                logic [NUM_W-1:0] num, logic [PAYLOAD_W-1:0] data,
                                logic [DLEN_W-1:0] dlen);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_mode     <= mode;
      req_frame_id <= ident;
      req_seg_type <= seg;
      req_seg_num  <= num;
      req_payload  <= data;
      req_data_len <= dlen;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(mode, ident, seg, num, data, dlen);
   endtask

   // the other fields of a tick are don't-care; keep them random
   task automatic send_tick();
      drive_request(MODE_TICK, rand_ident(), seg_type_type'($urandom_range(0, 3)),
                    NUM_W'($urandom_range(0, 63)), rand_payload(),
                    DLEN_W'($urandom_range(0, 15)));
   endtask

   task automatic send_frame(seg_type_type seg, logic [ID_W-1:0] ident,
                             logic [NUM_W-1:0] num, logic [PAYLOAD_W-1:0] data,
                             logic [DLEN_W-1:0] dlen);
      drive_request(MODE_FRAME, ident, seg, num, data, dlen);
   endtask

   // Idle the request side until every predicted chunk is out, then give
   // the block time to finish a request that produced no chunk.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Only called with the block idle.
   task automatic write_timeout(logic [AGE_W-1:0] t);
      csr_valid         <= 1'b1;
      csr_timeout_ticks <= t;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_timeout(t);
      csr_valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Directed requests at the reset timeout
   // ---------------------------------------------------------------------
   task automatic directed_cases();
      send_tick();
      send_frame(SEG_SINGLE, 29'h0000_0123, 6'd0, rand_payload(), 4'd8);
      // id 0 equals the cleared slot id, but no slot is in use: both dropped
      send_frame(SEG_MIDDLE, '0, 6'd1, rand_payload(), 4'd8);
      send_frame(SEG_END, '0, 6'd1, rand_payload(), 4'd8);
      // begin ignores seg_num; chunk 0 all ones
      send_frame(SEG_BEGIN, '0, 6'd63, '1, 4'd8);
      send_frame(SEG_MIDDLE, '0, 6'd1, '0, 4'd1);
      // position past the slot: nothing stored, length still grows
      send_frame(SEG_MIDDLE, '0, 6'd63, rand_payload(), 4'd8);
      // four chunks out, the fourth read from an untouched position
      send_frame(SEG_END, '0, 6'd2, rand_payload(), 4'd8);
      // fill all four slots
      send_frame(SEG_BEGIN, ID_TOP, 6'd0, rand_payload(), 4'd8);
      send_frame(SEG_BEGIN, 29'h0AAA_AAAA, 6'd0, rand_payload(), 4'd8);
      send_frame(SEG_BEGIN, 29'h1555_5555, 6'd0, rand_payload(), 4'd8);
      send_frame(SEG_BEGIN, 29'h0000_0001, 6'd0, rand_payload(), 4'd8);
      // every slot busy: begin dropped, so its middle finds no slot
      send_frame(SEG_BEGIN, 29'h0000_0002, 6'd0, rand_payload(), 4'd8);
      send_frame(SEG_MIDDLE, 29'h0000_0002, 6'd1, rand_payload(), 4'd8);
      // begin on an id in use restarts that slot
      send_frame(SEG_BEGIN, ID_TOP, 6'd0, '1, 4'd8);
      // end with one length byte only: no new bytes
      send_frame(SEG_END, 29'h0AAA_AAAA, 6'd0, rand_payload(), 4'd1);
      // end over chunk 0 keeps nothing of the begin payload
      send_frame(SEG_END, 29'h1555_5555, 6'd0, rand_payload(), 4'd8);
      // length code above eight counts as seven bytes
      send_frame(SEG_END, 29'h0000_0001, 6'd1, rand_payload(), 4'd15);
      send_frame(SEG_MIDDLE, ID_TOP, 6'd15, rand_payload(), 4'd0);
      // length code zero: no bytes, gap chunks come from the store
      send_frame(SEG_END, ID_TOP, 6'd3, rand_payload(), 4'd0);
      drive_request(MODE_TICK, ID_TOP, SEG_END, '1, '1, '1);
   endtask

   // With a timeout of one tick: one idle tick is still fine, two expire.
   task automatic short_timeout_cases();
      send_frame(SEG_BEGIN, 29'h0000_0055, 6'd0, rand_payload(), 4'd8);
      send_tick();
      send_frame(SEG_END, 29'h0000_0055, 6'd1, rand_payload(), 4'd5);
      send_frame(SEG_BEGIN, 29'h0000_0066, 6'd0, rand_payload(), 4'd8);
      send_tick();
      send_tick();
      send_frame(SEG_MIDDLE, 29'h0000_0066, 6'd1, rand_payload(), 4'd8);
      send_frame(SEG_END, 29'h0000_0066, 6'd2, rand_payload(), 4'd8);
   endtask

   // With the largest timeout a slot left idle over a tick burst stays open.
   task automatic long_idle_case();
      send_frame(SEG_BEGIN, 29'h0000_0077, 6'd0, rand_payload(), 4'd8);
      sender_gaps = 1'b0;
      repeat (TICK_BURST) send_tick();
      sender_gaps = 1'b1;
      send_frame(SEG_END, 29'h0000_0077, 6'd1, rand_payload(), 4'd8);
   endtask

   // ---------------------------------------------------------------------
   // Random traffic: four interleaved well-formed messages (begin, some
   // middles, end) with random content, plus noise between them.
   // ---------------------------------------------------------------------
   task automatic random_traffic(int n_items, bit with_hold, bit with_pause);
      localparam int OPEN = 4;
      logic [ID_W-1:0] msg_ident [OPEN];
      int msg_next [OPEN];
      int msg_left [OPEN];    // -1: no message open
      int k;
      int r;
      int num;
      for (int i = 0; i < OPEN; i++) begin
         msg_ident[i] = '0;
         msg_next[i]  = 1;
         msg_left[i]  = -1;
      end
      for (int n = 0; n < n_items; n++) begin
         // block fills up behind a stopped output while requests keep coming
         if (with_hold && n == n_items / 3) rsp_hold_req = 1'b1;
         // sender stops until everything is out
         if (with_pause && n == (2 * n_items) / 3) drain();
         r = $urandom_range(0, 99);
         k = $urandom_range(0, OPEN - 1);
         if (r < 15) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: send_tick();
               4: send_frame(SEG_SINGLE, rand_ident(), NUM_W'($urandom_range(0, 63)),
                             rand_payload(), pick_dlen());
               5: send_frame(SEG_MIDDLE, rand_ident(), NUM_W'($urandom_range(0, 63)),
                             rand_payload(), pick_dlen());
               6: send_frame(SEG_END, rand_ident(), NUM_W'($urandom_range(0, 63)),
                             rand_payload(), pick_dlen());
               7: begin
                  // restart of an open message
                  if (msg_left[k] >= 0)
                     send_frame(SEG_BEGIN, msg_ident[k], NUM_W'($urandom_range(0, 63)),
                                rand_payload(), pick_dlen());
                  else
                     send_tick();
               end
               8: begin
                  // early end; the rest of that message is then dropped
                  if (msg_left[k] >= 0)
                     send_frame(SEG_END, msg_ident[k], NUM_W'($urandom_range(0, 63)),
                                rand_payload(), pick_dlen());
                  else
                     send_tick();
               end
               default: repeat ($urandom_range(2, 6)) send_tick();
            endcase
         end else if (msg_left[k] < 0) begin
            msg_ident[k] = rand_ident();
            msg_next[k]  = 1;
            r = $urandom_range(0, 99);
            if (r < 80) msg_left[k] = $urandom_range(0, 4);
            else if (r < 95) msg_left[k] = $urandom_range(5, 14);
            else msg_left[k] = $urandom_range(15, 20);   // runs past the capacity
            send_frame(SEG_BEGIN, msg_ident[k], NUM_W'($urandom_range(0, 63)),
                       rand_payload(), pick_dlen());
         end else begin
            num = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 63) : msg_next[k];
            if (msg_left[k] > 0) begin
               send_frame(SEG_MIDDLE, msg_ident[k], NUM_W'(num), rand_payload(), pick_dlen());
               msg_next[k]++;
               msg_left[k]--;
            end else begin
               send_frame(SEG_END, msg_ident[k], NUM_W'(num), rand_payload(), pick_dlen());
               msg_left[k] = -1;
            end
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Response side: checks every accepted chunk, stalls at random, and
   // serves the one long hold-off counted here.
   // ---------------------------------------------------------------------
   initial begin : rsp_side
      chunk_rec_type got;
      int stall_left;
      int steady_left;
      int hold_left;
      int r;
      stall_left  = 0;
      steady_left = 0;
      hold_left   = 0;
      wait (!reset);
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            got = {rsp_msg_id, rsp_chunk, rsp_chunk_bytes, rsp_total_len, rsp_last};
            sb.check_chunk(got);
         end
         if (rsp_hold_req) begin
            rsp_hold_req = 1'b0;
            hold_left    = RSP_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (steady_left > 0) begin
            steady_left--;
            rsp_ready <= 1'b1;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 18) begin
               stall_left = $urandom_range(0, 2);
               rsp_ready <= 1'b0;
            end else if (r < 22) begin
               stall_left = $urandom_range(8, 40);
               rsp_ready <= 1'b0;
            end else if (r < 26) begin
               steady_left = $urandom_range(30, 150);
               rsp_ready <= 1'b1;
            end else begin
               rsp_ready <= 1'b1;
            end
         end
      end
   end

   // Hang detector: any accepted request, chunk or register write resets it.
   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            idle = 0;
         else
            idle++;
      end
      $display("%0t: no handshake for %0d cycles, %0d chunks still due",
               $time, IDLE_LIMIT, sb.outstanding());
      $display("** can_segmented_frame_reassembler_core: FAILED **");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Phases. Timeout changes only with the block idle.
   // ---------------------------------------------------------------------
   initial begin : stimulus
      sb            = new();
      rsp_hold_req  = 1'b0;
      sender_gaps   = 1'b1;
      zero_gap_left = 0;
      timeout_mid   = $urandom_range(2, 60);
      timeout_last  = $urandom_range(1, 65535);
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset timeout
      directed_cases();
      drain();

      // timeout of one tick: slots expire after two idle ticks
      write_timeout(AGE_W'(1));
      short_timeout_cases();
      random_traffic(95, 1'b0, 1'b0);
      drain();

      // largest timeout: nothing ever expires
      write_timeout('1);
      long_idle_case();
      random_traffic(85, 1'b0, 1'b0);
      drain();

      // moderate timeout, with the long output hold and a full sender pause
      write_timeout(AGE_W'(timeout_mid));
      random_traffic(145, 1'b1, 1'b1);
      drain();

      write_timeout(AGE_W'(timeout_last));
      random_traffic(115, 1'b0, 1'b0);
      drain();

      $display("Checked %0d chunks of %0d messages over %0d frames and %0d ticks, %0d expiries.",
               sb.chunks_checked, sb.messages_done, sb.frames_seen, sb.ticks_seen,
               sb.expiries);
      $display("Timeouts 5000, 1, 65535, %0d, %0d; one long output hold, one full drain.",
               timeout_mid, timeout_last);
      if (sb.failures == 0 && sb.outstanding() == 0)
         $display("** can_segmented_frame_reassembler_core: PASSED **");
      else
         $display("** can_segmented_frame_reassembler_core: FAILED **");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/csfr_pkg.sv
rtl/csfr_ram.sv
rtl/csfr_ctrl.sv
rtl/csfr_datapath.sv
rtl/can_segmented_frame_reassembler_core.sv
tb/sv/csfr_tb_pkg.sv
tb/sv/can_segmented_frame_reassembler_core_tb.sv
